FILE: rtl/wdad_pkg.sv
// Shared types, codes and constants of the windowed absolute difference detector.
// Used by the top level; depends on nothing.

package wdad_pkg;

    // Default sizes of the pixel stores and the window
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_RADIUS = 7;

    // Field widths fixed by the interface
    localparam int COORD_W = 9;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 10;

    // Register reset values
    localparam logic [9:0] FRAME_WIDTH_RESET   = 10'd512;
    localparam logic [9:0] FRAME_HEIGHT_RESET  = 10'd512;
    localparam logic [2:0] WINDOW_RADIUS_RESET = 3'd1;
    localparam logic [7:0] THRESHOLD_RESET     = 8'd0;

    // Level given when the mean exceeds the threshold
    localparam logic [7:0] LEVEL_HIGH = 8'd255;
    localparam logic [7:0] LEVEL_LOW  = 8'd0;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2,
        REG_THRESHOLD     = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_COMPARE,
        ST_DIVIDE
    } state_t;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel_first;
        logic [PIX_W-1:0]   pixel_second;
    } item_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] window_count;
        logic       out_of_frame;
    } result_t;

endpackage

FILE: rtl/wdad_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by the top level for the window mean.

module wdad_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W:0]    rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [DEN_W:0]    rem_shift;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (run_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next  = rem_shift - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: rtl/windowed_abs_difference_detector.sv
// Top level of the windowed absolute difference detector: pixel store,
// window sequencer and result logic. Depends on wdad_pkg and wdad_div.
//
// Usage:
//   Items enter on item when start is high and busy is low. A write item
//   stores a pixel pair and gives no result; busy stays low. A query item
//   inside the active frame raises busy until its result is issued; a query
//   outside it leaves busy low and gives its result in the cycle after
//   acceptance. Otherwise the window is read from the pixel store one pair
//   per cycle through its single read port, and without thresholding the
//   mean is then taken by the bit-serial divider. SUM_W, the width of the
//   difference sum, is 16 bits at the default sizes.
//   Each result is shown for one cycle with result_valid high; the receiver
//   must take it then. busy falls in that same cycle, so the next item may
//   be accepted while the result is on the ports.
//   Registers are written on the cfg channel (cfg_ready is always high);
//   the user must write them only while the block is idle, and the block
//   does not enforce this. Reset restores the defaults and returns to idle;
//   the pixel store is not cleared and holds arbitrary data until written.

module windowed_abs_difference_detector
    import wdad_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  item_t            item,
    output logic             busy,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int HB      = $clog2(MAX_HEIGHT + 1);
    localparam int WHB     = (WB > HB) ? WB : HB;
    localparam int DIM_W   = (WHB > CFG_W) ? WHB : CFG_W;
    localparam int MAX_CNT = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W   = $clog2(MAX_CNT + 1);
    localparam int SUM_W   = $clog2(MAX_CNT * 255 + 1);
    localparam int PROD_W  = PIX_W + CNT_W;

    // Pixel store: second frame in the upper byte, first in the lower
    logic [2*PIX_W-1:0] store_mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // Configuration registers
    logic [9:0] frame_width_reg;
    logic [9:0] frame_height_reg;
    logic [2:0] window_radius_reg;
    logic [7:0] threshold_reg;

    // Sequencer
    state_t state_reg, state_next;
    logic   rd_valid_reg, rd_valid_next;
    logic   result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic [XW-1:0]     x0_reg, x0_next, x1_reg, x1_next, x_reg, x_next;
    logic [YW-1:0]     y0_reg, y0_next, y1_reg, y1_next, y_reg, y_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // Clipped window bounds of the item on the input
    logic [DIM_W-1:0] w_eff, h_eff, r_eff, col_ext, row_ext;
    logic [DIM_W-1:0] x0_c, x1_c, y0_c, y1_c;
    logic             outside;
    logic [PIX_W-1:0] pix_a, pix_b, abs_diff;

    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_quot;

    // Saturate the registers to the store sizes
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(frame_width_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(frame_width_reg);

        if (frame_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(frame_height_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(frame_height_reg);

        if (DIM_W'(window_radius_reg) > DIM_W'(MAX_RADIUS))
            r_eff = DIM_W'(MAX_RADIUS);
        else
            r_eff = DIM_W'(window_radius_reg);
    end

    // Clip the window at the frame edges
    always_comb
    begin
        col_ext = DIM_W'(item.col);
        row_ext = DIM_W'(item.row);
        outside = (col_ext >= w_eff) || (row_ext >= h_eff);
        x0_c = (col_ext > r_eff) ? col_ext - r_eff : '0;
        y0_c = (row_ext > r_eff) ? row_ext - r_eff : '0;
        x1_c = (col_ext + r_eff < w_eff) ? col_ext + r_eff : w_eff - 1'b1;
        y1_c = (row_ext + r_eff < h_eff) ? row_ext + r_eff : h_eff - 1'b1;
    end

    // Absolute difference of the pair read last cycle
    always_comb
    begin
        pix_a    = rd_data_reg[PIX_W-1:0];
        pix_b    = rd_data_reg[2*PIX_W-1:PIX_W];
        abs_diff = (pix_b > pix_a) ? pix_b - pix_a : pix_a - pix_b;
    end

    // Next state, store accesses and result
    always_comb
    begin
        state_next        = state_reg;
        rd_valid_next     = 1'b0;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        x0_next           = x0_reg;
        x1_next           = x1_reg;
        y0_next           = y0_reg;
        y1_next           = y1_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        base_next         = base_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        prod_next         = prod_reg;
        wr_en             = 1'b0;
        wr_addr           = AW'(item.row) * AW'(MAX_WIDTH) + AW'(item.col);
        rd_en             = 1'b0;
        rd_addr           = base_reg + AW'(x_reg);
        div_start         = 1'b0;

        // Accumulate each pair in the cycle after its read
        if (rd_valid_reg)
        begin
            sum_next   = sum_reg + SUM_W'(abs_diff);
            count_next = count_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && item.action == ACT_WRITE)
                begin
                    wr_en = (DIM_W'(item.col) < DIM_W'(MAX_WIDTH))
                         && (DIM_W'(item.row) < DIM_W'(MAX_HEIGHT));
                end
                else if (start && item.action == ACT_QUERY)
                begin
                    x0_next = XW'(x0_c);
                    x1_next = XW'(x1_c);
                    y0_next = YW'(y0_c);
                    y1_next = YW'(y1_c);
                    if (outside)
                    begin
                        result_valid_next = 1'b1;
                        result_next.level        = LEVEL_LOW;
                        result_next.window_count = '0;
                        result_next.out_of_frame = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                x_next     = x0_reg;
                y_next     = y0_reg;
                base_next  = AW'(y0_reg) * AW'(MAX_WIDTH);
                sum_next   = '0;
                count_next = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                if (x_reg == x1_reg)
                begin
                    x_next = x0_reg;
                    if (y_reg == y1_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        y_next    = y_reg + 1'b1;
                        base_next = base_reg + AW'(MAX_WIDTH);
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (threshold_reg != '0)
                begin
                    prod_next  = PROD_W'(threshold_reg) * PROD_W'(count_reg);
                    state_next = ST_COMPARE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end

            ST_COMPARE:
            begin
                result_valid_next        = 1'b1;
                result_next.level        = ((PROD_W + SUM_W)'(sum_reg) >
                                            (PROD_W + SUM_W)'(prod_reg))
                                           ? LEVEL_HIGH : LEVEL_LOW;
                result_next.window_count = 8'(count_reg);
                result_next.out_of_frame = 1'b0;
                state_next               = ST_IDLE;
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    result_valid_next        = 1'b1;
                    result_next.level        = 8'(div_quot);
                    result_next.window_count = 8'(count_reg);
                    result_next.out_of_frame = 1'b0;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Mean of the window sum
    wdad_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (sum_reg),
        .denom (count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Write and read the pixel store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= {item.pixel_second, item.pixel_first};
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RESET;
            frame_height_reg  <= FRAME_HEIGHT_RESET;
            window_radius_reg <= WINDOW_RADIUS_RESET;
            threshold_reg     <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[9:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[9:0];
                REG_WINDOW_RADIUS: window_radius_reg <= cfg_data[2:0];
                REG_THRESHOLD:     threshold_reg     <= cfg_data[7:0];
                default:           frame_width_reg   <= frame_width_reg;
            endcase
        end
    end

    // Advance the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        base_reg   <= base_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        prod_reg   <= prod_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sv/tb_windowed_abs_difference_detector.sv
// Self-checking testbench for the windowed absolute difference detector: a scoreboard
// class predicts each query result from its own copy of both frames and the registers.
// Depends on wdad_pkg and the top level windowed_abs_difference_detector.

import wdad_pkg::*;

class window_mean_scoreboard;

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    logic [7:0]       first_px  [STORE_DEPTH];
    logic [7:0]       second_px [STORE_DEPTH];
    bit               written   [STORE_DEPTH];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [2:0]       radius_reg;
    logic [7:0]       threshold_reg;
    result_t          pending_results [$];
    int               errors;
    int               reported;

    function new();
        width_reg     = FRAME_WIDTH_RESET;
        height_reg    = FRAME_HEIGHT_RESET;
        radius_reg    = WINDOW_RADIUS_RESET;
        threshold_reg = THRESHOLD_RESET;
        errors        = 0;
        reported      = 0;
    endfunction

    // Saturate the size registers to the store dimensions
    function int active_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function int active_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > DEF_MAX_HEIGHT)
            return DEF_MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // Clip the window at the frame edges; return whether the pixel lies in the frame
    function bit window_of(input int col, input int row,
                           output int x0, output int x1, output int y0, output int y1);
        int w;
        int h;
        int r;
        w  = active_width();
        h  = active_height();
        r  = (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_reg);
        x0 = (col > r) ? col - r : 0;
        y0 = (row > r) ? row - r : 0;
        x1 = (col + r < w) ? col + r : w - 1;
        y1 = (row + r < h) ? row + r : h - 1;
        return (col < w) && (row < h);
    endfunction

    function void note_config(cfg_index_t idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:   width_reg     = data;
            REG_FRAME_HEIGHT:  height_reg    = data;
            REG_WINDOW_RADIUS: radius_reg    = data[2:0];
            REG_THRESHOLD:     threshold_reg = data[7:0];
            default: ;
        endcase
    endfunction

    // Mean absolute difference over the clipped window, or the binarized level
    function result_t predict_window_mean(item_t it);
        result_t res;
        int      x0;
        int      x1;
        int      y0;
        int      y1;
        int      sum;
        int      count;
        int      addr;
        int      p;
        int      q;
        res = '0;
        if (!window_of(int'(it.col), int'(it.row), x0, x1, y0, y1))
        begin
            res.out_of_frame = 1'b1;
            return res;
        end
        sum   = 0;
        count = 0;
        for (int y = y0; y <= y1; y++)
        begin
            for (int x = x0; x <= x1; x++)
            begin
                addr  = y * DEF_MAX_WIDTH + x;
                p     = int'(first_px[addr]);
                q     = int'(second_px[addr]);
                sum  += (q > p) ? q - p : p - q;
                count++;
            end
        end
        if (threshold_reg != 0)
            res.level = (sum > int'(threshold_reg) * count) ? LEVEL_HIGH
                                                            : LEVEL_LOW;
        else
            res.level = 8'(sum / count);
        res.window_count = 8'(count);
        return res;
    endfunction

    // Store a written pixel pair, or queue the result a query will give
    function void note_item(item_t it);
        int addr;
        if (it.action == ACT_WRITE)
        begin
            addr            = int'(it.row) * DEF_MAX_WIDTH + int'(it.col);
            first_px[addr]  = it.pixel_first;
            second_px[addr] = it.pixel_second;
            written[addr]   = 1'b1;
        end
        else
        begin
            pending_results.push_back(predict_window_mean(it));
        end
    endfunction

    function void note_failure(bit has_want, result_t want, result_t got);
        errors++;
        if (reported < 10)
        begin
            reported++;
            if (has_want)
                $display({"mismatch: expected level %0d count %0d out %0b, ",
                          "got level %0d count %0d out %0b"},
                         want.level, want.window_count, want.out_of_frame,
                         got.level, got.window_count, got.out_of_frame);
            else
                $display("unexpected result: level %0d count %0d out %0b",
                         got.level, got.window_count, got.out_of_frame);
        end
    endfunction

    // Compare a result beat with the oldest expectation
    function void check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            note_failure(1'b0, '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.level !== want.level || got.window_count !== want.window_count ||
            got.out_of_frame !== want.out_of_frame)
            note_failure(1'b1, want, got);
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

endclass

module tb_windowed_abs_difference_detector;

    localparam int RANDOM_ITEMS  = 1450;
    localparam int PHASES        = 10;
    // Idle time left for the block to settle after the last result
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    // Run limit, far above the worst query and the longest idle burst for every item
    localparam int CYCLE_LIMIT   = 8000000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    item_t            item;
    logic             busy;
    logic             result_valid;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    window_mean_scoreboard mean_model;
    bit                    idle_on;
    int                    cycle_count;
    int                    sent_count;
    int                    phase_end;

    windowed_abs_difference_detector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every result beat as it leaves the block
    always @(posedge clk)
    begin
        if (result_valid === 1'b1)
            mean_model.check_result(result);
    end

    // Abandon a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int idle_burst();
        if (!idle_on || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    // Hold the beat until the block takes it, then sometimes idle for a random burst
    task automatic send_item(item_t it);
        int gap;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mean_model.note_item(it);
        sent_count++;
        gap = idle_burst();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_pixel(int col, int row, logic [7:0] f, logic [7:0] s);
        item_t it;
        it.action       = ACT_WRITE;
        it.col          = COORD_W'(col);
        it.row          = COORD_W'(row);
        it.pixel_first  = f;
        it.pixel_second = s;
        send_item(it);
    endtask

    // Mix wide differences, near-equal pairs and extremes
    task automatic random_pair(output logic [7:0] f, output logic [7:0] s);
        f = 8'($urandom);
        case ($urandom_range(0, 3))
            0: s = 8'($urandom);
            1: s = f + 8'($urandom_range(0, 6)) - 8'd3;
            2:
            begin
                f = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                s = ($urandom_range(0, 1) != 0) ? f : ~f;
            end
            default: s = f;
        endcase
    endtask

    // Fill any unwritten pixel of the window first, then issue the query
    task automatic query_pixel(int col, int row);
        item_t      it;
        int         x0;
        int         x1;
        int         y0;
        int         y1;
        logic [7:0] f;
        logic [7:0] s;
        if (mean_model.window_of(col, row, x0, x1, y0, y1))
        begin
            for (int y = y0; y <= y1; y++)
            begin
                for (int x = x0; x <= x1; x++)
                begin
                    if (!mean_model.written[y * DEF_MAX_WIDTH + x])
                    begin
                        random_pair(f, s);
                        write_pixel(x, y, f, s);
                    end
                end
            end
        end
        it.action       = ACT_QUERY;
        it.col          = COORD_W'(col);
        it.row          = COORD_W'(row);
        it.pixel_first  = 8'($urandom);
        it.pixel_second = 8'($urandom);
        send_item(it);
    endtask

    // Drop start and wait until every result has come and the block has settled
    task automatic wait_idle();
        start <= 1'b0;
        while (mean_model.pending() > 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mean_model.note_config(idx, data);
    endtask

    task automatic set_registers(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                 logic [CFG_W-1:0] r, logic [CFG_W-1:0] t);
        wait_idle();
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
        write_register(REG_WINDOW_RADIUS, r);
        write_register(REG_THRESHOLD, t);
        cfg_valid <= 1'b0;
    endtask

    // Favour coordinates near both edges so that windows get clipped
    function automatic int pick_coord(int limit);
        int span;
        span = (limit > 8) ? 8 : limit;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, span - 1);
            1: return limit - 1 - int'($urandom_range(0, span - 1));
            default: return $urandom_range(0, limit - 1);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(512, 1023));
            2: return CFG_W'($urandom_range(0, 1023));
            default: return CFG_W'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_threshold();
        case ($urandom_range(0, 3))
            0, 1: return CFG_W'($urandom_range(0, 3) << 8);
            2: return CFG_W'($urandom_range(1, 40));
            default: return CFG_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic random_item();
        int         w;
        int         h;
        int         kind;
        int         col;
        int         row;
        logic [7:0] f;
        logic [7:0] s;
        w    = mean_model.active_width();
        h    = mean_model.active_height();
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            // Writes land mostly in the active frame, some anywhere in the store
            if ($urandom_range(0, 5) == 0)
            begin
                col = $urandom_range(0, DEF_MAX_WIDTH - 1);
                row = $urandom_range(0, DEF_MAX_HEIGHT - 1);
            end
            else
            begin
                col = pick_coord(w);
                row = pick_coord(h);
            end
            random_pair(f, s);
            write_pixel(col, row, f, s);
        end
        else if (kind < 90 || (w == DEF_MAX_WIDTH && h == DEF_MAX_HEIGHT))
            query_pixel(pick_coord(w), pick_coord(h));
        else if (w < DEF_MAX_WIDTH && (h == DEF_MAX_HEIGHT || $urandom_range(0, 1) != 0))
            query_pixel($urandom_range(w, DEF_MAX_WIDTH - 1),
                        $urandom_range(0, DEF_MAX_HEIGHT - 1));
        else
            query_pixel($urandom_range(0, DEF_MAX_WIDTH - 1),
                        $urandom_range(h, DEF_MAX_HEIGHT - 1));
    endtask

    task automatic directed_items();
        // Reset settings: full frame, radius one, no threshold
        write_pixel(0, 0, 8'd0, 8'd255);
        write_pixel(1, 0, 8'd255, 8'd0);
        write_pixel(0, 1, 8'd0, 8'd0);
        write_pixel(1, 1, 8'd255, 8'd255);
        query_pixel(0, 0);
        write_pixel(511, 511, 8'd255, 8'd0);
        query_pixel(511, 511);
        query_pixel(511, 0);
        query_pixel(0, 511);
        // Radius zero on a small frame, with queries just past each edge
        set_registers(10'd16, 10'd16, 10'd0, 10'd0);
        query_pixel(0, 0);
        query_pixel(16, 0);
        query_pixel(0, 16);
        query_pixel(511, 511);
        query_pixel(15, 15);
        // Sizes saturated at both ends, largest radius, highest threshold
        set_registers(10'd0, 10'd1023, 10'd7, 10'd255);
        query_pixel(0, 0);
        query_pixel(1, 0);
        query_pixel(0, 511);
        // Single pixel frame with the lowest threshold, both above and at the level
        set_registers(10'd1, 10'd1, 10'd7, 10'd1);
        query_pixel(0, 0);
        write_pixel(0, 0, 8'd7, 8'd7);
        query_pixel(0, 0);
        write_pixel(0, 0, 8'd7, 8'd8);
        query_pixel(0, 0);
    endtask

    initial
    begin
        mean_model = new();
        idle_on    = 1'b1;
        sent_count = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // Run the random part in phases, each under new register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_registers(10'd16, 10'd16, 10'd0, 10'd0);
                1: set_registers(10'd0, 10'd1023, 10'd7, 10'd255);
                2: set_registers(10'd1, 10'd0, 10'd7, 10'd0);
                3: set_registers(10'd512, 10'd512, 10'd7, 10'd1);
                default: set_registers(random_size(), random_size(),
                                       CFG_W'($urandom_range(0, 1023)), random_threshold());
            endcase
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            // Count window fills against the item budget of the phase
            phase_end = sent_count + RANDOM_ITEMS / PHASES;
            while (sent_count < phase_end)
            begin
                random_item();
                if (phase != PHASES - 1 && $urandom_range(0, 149) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        mean_model.errors += mean_model.pending();
        if (mean_model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
